// ===== rtl/core/bbis_pkg.sv =====
// Shared types and constants for the bilinear/bicubic image scaler.
// No dependencies; imported by the scaler top level and its testbench.
package bbis_pkg;

  localparam int MAX_SRC_DIM = 256;
  localparam int FRAC_BITS   = 16;

  localparam int CX_W     = 12;
  localparam int CY_W     = 12;
  localparam int RGBA_W   = 32;
  localparam int DIM_W    = $clog2(MAX_SRC_DIM) + 1;
  localparam int STEP_W   = FRAC_BITS + 9;
  localparam int CFG_IX_W = 2;
  localparam int IN_DATA_W = 56;

  typedef logic [CFG_IX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_SRC_WIDTH  = 2'd0;
  localparam cfg_index_t REG_SRC_HEIGHT = 2'd1;
  localparam cfg_index_t REG_X_STEP     = 2'd2;
  localparam cfg_index_t REG_Y_STEP     = 2'd3;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

endpackage

// ===== rtl/core/bbis_mul.sv =====
// Shared registered multiplier: signed operand times unsigned weight.
// Depends on nothing; used by the scaler sequencer for every product.
module bbis_mul #(
  parameter int AW = 36,
  parameter int BW = 17
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic        [BW-1:0]    b,
  output logic signed [AW+BW:0]   p
);

  always_ff @(posedge clk) begin
    p <= (AW+BW+1)'(a) * (AW+BW+1)'($signed({1'b0, b}));
  end

endmodule

// ===== rtl/core/bilinear_bicubic_image_scaler.sv =====
// Image scaler top level: frame store, tap fetch and filter sequencer.
// Depends on bbis_pkg and bbis_mul.
//
//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | s_tdata coord_x,coord_y,load_rgba; s_tuser mode
//  m_*      | out | m_tvalid/m_tready  | m_tdata out_rgba
//  cfg_*    | in  | cfg_we             | cfg_index, cfg_data
//
// A load is written while idle if it lies inside the source. A request passes the
// mapping states (MAPX, MAPY), a tap fetch of one frame read per cycle (16
// bicubic, 4 bilinear) and a drain state, then the shared multiplier sequence
// (bicubic or bilinear) and an output state. s_tready is high only while idle;
// a finished pixel waits while m_tvalid is held and m_tready is low. Reset is
// synchronous; the frame store is not cleared.
module bilinear_bicubic_image_scaler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bbis_pkg::IN_DATA_W-1:0] s_tdata,  // coord_x, coord_y, load_rgba
  input  logic                          s_tuser,   // mode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bbis_pkg::RGBA_W-1:0]   m_tdata,   // out_rgba
  input  logic                          cfg_we,
  input  bbis_pkg::cfg_index_t          cfg_index,
  input  logic [bbis_pkg::STEP_W-1:0]   cfg_data
);
  import bbis_pkg::*;

  localparam int DW   = $clog2(MAX_SRC_DIM);
  localparam int EW   = $clog2(MAX_SRC_DIM + 1);
  localparam int AW   = $clog2(MAX_SRC_DIM * MAX_SRC_DIM);
  localparam int PXW  = CX_W + STEP_W;
  localparam int IXW  = PXW - FRAC_BITS;
  localparam int HW   = FRAC_BITS + 20;
  localparam int SCW  = FRAC_BITS + 1;
  localparam int PW   = HW + SCW + 1;
  localparam int ACCW = 2 * FRAC_BITS + 9;
  localparam logic [31:0] BIC_HI = 32'(4) << FRAC_BITS;
  localparam logic [31:0] BIC_LO = 32'(1) << (FRAC_BITS - 2);
  localparam logic [SCW-1:0] ONE = SCW'(1) << FRAC_BITS;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MAPX  = 4'd1;
  localparam logic [3:0] ST_MAPY  = 4'd2;
  localparam logic [3:0] ST_FETCH = 4'd3;
  localparam logic [3:0] ST_DRAIN = 4'd4;
  localparam logic [3:0] ST_CINIT = 4'd5;
  localparam logic [3:0] ST_CMUL  = 4'd6;
  localparam logic [3:0] ST_CADD  = 4'd7;
  localparam logic [3:0] ST_BMUL  = 4'd8;
  localparam logic [3:0] ST_BACC  = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  logic [DIM_W-1:0]  src_width, src_height;
  logic [STEP_W-1:0] x_step, y_step;
  logic [EW-1:0]     w_eff, h_eff;

  logic [3:0]        state;
  logic [CX_W-1:0]   cx;
  logic [CY_W-1:0]   cy;
  logic [PXW-1:0]    px, py, map_p;
  logic [3:0]        k, rd_k;
  logic              rd_pend;
  logic [RGBA_W-1:0] mem_q;
  logic [RGBA_W-1:0] taps [16];
  logic [1:0]        ch, n;
  logic [2:0]        cub, bn;
  logic signed [HW-1:0] h, h_next, sh;
  logic signed [HW-1:0] colv [4];
  logic signed [HW-1:0] in_v [4];
  logic signed [HW-1:0] ca, cb, cc, cd, coef;
  logic [HW-1:0]     top, bot, vs;
  logic [ACCW-1:0]   acc, acc_next, vb;
  logic [RGBA_W-1:0] pix;
  logic [7:0]        byte_c, byte_b;

  logic [RGBA_W-1:0] frame [MAX_SRC_DIM*MAX_SRC_DIM];
  logic              load_ok;
  logic [AW-1:0]     waddr, raddr;

  logic              bic;
  logic [IXW-1:0]    ix, iy;
  logic [FRAC_BITS-1:0] fx, fy, t;
  logic [IXW+1:0]    xs, ys;
  logic [DW-1:0]     xc, yc;

  logic signed [HW-1:0] mul_a;
  logic [SCW-1:0]    mul_b;
  logic signed [PW-1:0] mul_p;

  // effective source size
  always_comb begin
    if (src_width == '0) w_eff = EW'(1);
    else if (32'(src_width) > 32'(MAX_SRC_DIM)) w_eff = EW'(MAX_SRC_DIM);
    else w_eff = EW'(src_width);
    if (src_height == '0) h_eff = EW'(1);
    else if (32'(src_height) > 32'(MAX_SRC_DIM)) h_eff = EW'(MAX_SRC_DIM);
    else h_eff = EW'(src_height);
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= DIM_W'(MAX_SRC_DIM);
      src_height <= DIM_W'(MAX_SRC_DIM);
      x_step     <= STEP_W'(1) << FRAC_BITS;
      y_step     <= STEP_W'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[DIM_W-1:0];
        REG_X_STEP:     x_step     <= cfg_data;
        REG_Y_STEP:     y_step     <= cfg_data;
      endcase
    end
  end

  // frame store
  assign load_ok = (32'(s_tdata[CX_W-1:0]) < 32'(w_eff)) &&
                   (32'(s_tdata[CX_W+CY_W-1:CX_W]) < 32'(h_eff));
  assign waddr = AW'(32'(s_tdata[CX_W+CY_W-1:CX_W]) * MAX_SRC_DIM +
                     32'(s_tdata[CX_W-1:0]));

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && s_tuser == MODE_LOAD && load_ok) begin
      frame[waddr] <= s_tdata[CX_W+CY_W+RGBA_W-1:CX_W+CY_W];
    end
    if (state == ST_FETCH) begin
      mem_q <= frame[raddr];
    end
  end

  // source position and tap address
  assign map_p = (state == ST_MAPY) ? PXW'(cy) * PXW'(y_step) : PXW'(cx) * PXW'(x_step);
  assign ix  = px[PXW-1:FRAC_BITS];
  assign iy  = py[PXW-1:FRAC_BITS];
  assign fx  = px[FRAC_BITS-1:0];
  assign fy  = py[FRAC_BITS-1:0];
  assign bic = !((32'(x_step) > BIC_HI) || (32'(x_step) < BIC_LO));

  always_comb begin
    if (bic) begin
      xs = {2'b00, ix} + (IXW+2)'(k[1:0]) - (IXW+2)'(1);
      ys = {2'b00, iy} + (IXW+2)'(k[3:2]) - (IXW+2)'(1);
    end else begin
      xs = {2'b00, ix} + (IXW+2)'(k[0]);
      ys = {2'b00, iy} + (IXW+2)'(k[1]);
    end
    if (xs[IXW+1]) xc = '0;
    else if (32'(xs) >= 32'(w_eff)) xc = DW'(w_eff - EW'(1));
    else xc = DW'(xs);
    if (ys[IXW+1]) yc = '0;
    else if (32'(ys) >= 32'(h_eff)) yc = DW'(h_eff - EW'(1));
    else yc = DW'(ys);
  end
  assign raddr = AW'(32'(yc) * MAX_SRC_DIM + 32'(xc));

  // cubic inputs and doubled Catmull-Rom coefficients
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (cub == 3'd4) in_v[j] = colv[j];
      else in_v[j] = HW'({taps[{cub[1:0], 2'(j)}][ch*8 +: 8], {FRAC_BITS{1'b0}}});
    end
    ca = (in_v[3] - in_v[0]) + ((in_v[1] - in_v[2]) <<< 1) + (in_v[1] - in_v[2]);
    cb = (in_v[0] <<< 1) - (in_v[1] <<< 2) - in_v[1] + (in_v[2] <<< 2) - in_v[3];
    cc = in_v[2] - in_v[0];
    cd = in_v[1] <<< 1;
    unique case (n)
      2'd0:    coef = cb;
      2'd1:    coef = cc;
      default: coef = cd;
    endcase
    t = (cub == 3'd4) ? fy : fx;
    sh = HW'(mul_p >>> FRAC_BITS);
    h_next = sh + coef;
    vs = HW'(h_next) >> (FRAC_BITS + 2);
    if (h_next[HW-1]) byte_c = 8'd0;
    else if (vs > HW'(255)) byte_c = 8'd255;
    else byte_c = vs[7:0];
    acc_next = acc + ACCW'(mul_p);
    vb = acc_next >> (2 * FRAC_BITS);
    byte_b = (vb > ACCW'(255)) ? 8'd255 : vb[7:0];
  end

  // shared multiplier operands
  always_comb begin
    mul_a = h;
    mul_b = {1'b0, t};
    if (state == ST_BMUL) begin
      unique case (bn)
        3'd0: begin mul_a = HW'(taps[0][ch*8 +: 8]); mul_b = ONE - SCW'(fx); end
        3'd1: begin mul_a = HW'(taps[1][ch*8 +: 8]); mul_b = SCW'(fx); end
        3'd2: begin mul_a = HW'(taps[2][ch*8 +: 8]); mul_b = ONE - SCW'(fx); end
        3'd3: begin mul_a = HW'(taps[3][ch*8 +: 8]); mul_b = SCW'(fx); end
        3'd4: begin mul_a = $signed(top); mul_b = ONE - SCW'(fy); end
        default: begin mul_a = $signed(bot); mul_b = SCW'(fy); end
      endcase
    end
  end

  bbis_mul #(.AW(HW), .BW(SCW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_pend <= (state == ST_FETCH);
      rd_k    <= k;
      if (rd_pend) taps[rd_k] <= mem_q;
      // in ST_DONE a taken output is refilled below
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tuser == MODE_REQUEST) begin
            cx    <= s_tdata[CX_W-1:0];
            cy    <= s_tdata[CX_W+CY_W-1:CX_W];
            state <= ST_MAPX;
          end
        end
        ST_MAPX: begin
          px    <= map_p;
          state <= ST_MAPY;
        end
        ST_MAPY: begin
          py    <= map_p;
          k     <= '0;
          state <= ST_FETCH;
        end
        ST_FETCH: begin
          k <= k + 4'd1;
          if ((bic && k == 4'd15) || (!bic && k == 4'd3)) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          ch    <= '0;
          cub   <= '0;
          bn    <= '0;
          state <= bic ? ST_CINIT : ST_BMUL;
        end
        ST_CINIT: begin
          h     <= ca;
          n     <= '0;
          state <= ST_CMUL;
        end
        ST_CMUL: state <= ST_CADD;
        ST_CADD: begin
          h <= h_next;
          n <= n + 2'd1;
          if (n != 2'd2) begin
            state <= ST_CMUL;
          end else if (cub != 3'd4) begin
            colv[cub[1:0]] <= h_next;
            cub   <= cub + 3'd1;
            state <= ST_CINIT;
          end else begin
            pix[ch*8 +: 8] <= byte_c;
            cub   <= '0;
            ch    <= ch + 2'd1;
            state <= (ch == 2'd3) ? ST_DONE : ST_CINIT;
          end
        end
        ST_BMUL: state <= ST_BACC;
        ST_BACC: begin
          unique case (bn)
            3'd0: top <= HW'(mul_p);
            3'd1: top <= top + HW'(mul_p);
            3'd2: bot <= HW'(mul_p);
            3'd3: bot <= bot + HW'(mul_p);
            3'd4: acc <= ACCW'(mul_p);
            default: begin
              pix[ch*8 +: 8] <= byte_b;
              ch <= ch + 2'd1;
            end
          endcase
          if (bn == 3'd5) begin
            bn    <= '0;
            state <= (ch == 2'd3) ? ST_DONE : ST_BMUL;
          end else begin
            bn    <= bn + 3'd1;
            state <= ST_BMUL;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= pix;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb_bilinear_bicubic_image_scaler.sv =====
// Self-checking testbench for the bilinear/bicubic image scaler: loads frames,
// requests resampled pixels and compares them with an in-bench pixel predictor.
// Depends on bbis_pkg and the scaler RTL.
module tb_bilinear_bicubic_image_scaler;
  import bbis_pkg::*;

  localparam int FRAC       = 16;
  localparam int FRAME_DIM  = 256;
  localparam longint ONE_Q  = 64'd1 << FRAC;
  localparam int CYCLE_LIMIT = 3_000_000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [RGBA_W-1:0]     m_tdata;
  logic                  cfg_we;
  cfg_index_t            cfg_index;
  logic [STEP_W-1:0]     cfg_data;

  bilinear_bicubic_image_scaler dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [RGBA_W-1:0] frame_mem [0:FRAME_DIM*FRAME_DIM-1];
  logic [DIM_W-1:0]  width_reg, height_reg;
  logic [STEP_W-1:0] xstep_reg, ystep_reg;
  logic [RGBA_W-1:0] pixel_queue [$];

  int  errors;
  int  accepted;
  int  items_sent;
  longint cycles;
  bit  calm_in, calm_out;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint eff_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > FRAME_DIM) return FRAME_DIM;
    return longint'(v);
  endfunction

  function automatic longint pix(longint x, longint y, longint w, longint h, int ch);
    if (x < 0) x = 0;
    if (x >= w) x = w - 1;
    if (y < 0) y = 0;
    if (y >= h) y = h - 1;
    return longint'((frame_mem[y * FRAME_DIM + x] >> (8 * ch)) & 32'hFF);
  endfunction

  function automatic longint catmull(longint a, longint b, longint c, longint d,
                                     longint t);
    longint acc;
    acc = -a + 3 * b - 3 * c + d;
    acc = ((acc * t) >>> FRAC) + (2 * a - 5 * b + 4 * c - d);
    acc = ((acc * t) >>> FRAC) + (c - a);
    acc = ((acc * t) >>> FRAC) + 2 * b;
    return acc;
  endfunction

  function automatic logic [RGBA_W-1:0] resample(logic [CX_W-1:0] dx,
                                                 logic [CY_W-1:0] dy);
    longint w, h, px, py, ix, iy, fx, fy, v, x1, y1, x2, y2, top, bot;
    longint col [4];
    bit cubic;
    logic [RGBA_W-1:0] res;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    px = longint'(dx) * longint'(xstep_reg);
    py = longint'(dy) * longint'(ystep_reg);
    ix = px >> FRAC;
    iy = py >> FRAC;
    fx = px & (ONE_Q - 1);
    fy = py & (ONE_Q - 1);
    cubic = !(xstep_reg > (4 << FRAC) || xstep_reg < (1 << (FRAC - 2)));
    res = '0;
    for (int ch = 0; ch < 4; ch++) begin
      if (cubic) begin
        for (int k = 0; k < 4; k++)
          col[k] = catmull(pix(ix - 1, iy - 1 + k, w, h, ch) << FRAC,
                           pix(ix, iy - 1 + k, w, h, ch) << FRAC,
                           pix(ix + 1, iy - 1 + k, w, h, ch) << FRAC,
                           pix(ix + 2, iy - 1 + k, w, h, ch) << FRAC, fx);
        v = catmull(col[0], col[1], col[2], col[3], fy);
        if (v < 0) v = 0;
        else v = v >> (FRAC + 2);
      end else begin
        x1 = ix < w ? ix : w - 1;
        y1 = iy < h ? iy : h - 1;
        x2 = x1 + 1 < w ? x1 + 1 : x1;
        y2 = y1 + 1 < h ? y1 + 1 : y1;
        top = pix(x1, y1, w, h, ch) * (ONE_Q - fx) + pix(x2, y1, w, h, ch) * fx;
        bot = pix(x1, y2, w, h, ch) * (ONE_Q - fx) + pix(x2, y2, w, h, ch) * fx;
        v = (top * (ONE_Q - fy) + bot * fy) >> (2 * FRAC);
      end
      if (v > 255) v = 255;
      res[8*ch +: 8] = v[7:0];
    end
    return res;
  endfunction

  // accepted requests update the frame or queue an expected pixel
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      accepted <= accepted + 1;
      if (s_tuser == MODE_LOAD) begin
        if (longint'(s_tdata[11:0]) < eff_dim(width_reg) &&
            longint'(s_tdata[23:12]) < eff_dim(height_reg))
          frame_mem[s_tdata[23:12] * FRAME_DIM + s_tdata[11:0]] = s_tdata[55:24];
      end else begin
        pixel_queue.push_back(resample(s_tdata[11:0], s_tdata[23:12]));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pixel_queue.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %08h", $time, m_tdata);
        errors++;
      end else begin
        if (m_tdata !== pixel_queue[0]) begin
          $display("%0t: out_rgba mismatch, expected %08h, actual %08h",
                   $time, pixel_queue[0], m_tdata);
          errors++;
        end
        void'(pixel_queue.pop_front());
      end
    end
  end

  function automatic int gap_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls
  initial begin
    int n;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      n = gap_len(calm_out);
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  task automatic send_item(logic mode, logic [CX_W-1:0] cx, logic [CY_W-1:0] cy,
                           logic [RGBA_W-1:0] rgba);
    int seen;
    int n;
    seen = accepted;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {rgba, cy, cx};
    do @(negedge clk); while (accepted == seen);
    items_sent++;
    n = gap_len(calm_in);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic load_px(int x, int y, logic [RGBA_W-1:0] v);
    send_item(MODE_LOAD, x[CX_W-1:0], y[CY_W-1:0], v);
  endtask

  task automatic request_px(int x, int y);
    send_item(MODE_REQUEST, x[CX_W-1:0], y[CY_W-1:0], '0);
  endtask

  // hold off until every pixel is back and the block has settled
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pixel_queue.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t ix, logic [STEP_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= ix;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (ix)
      REG_SRC_WIDTH:  width_reg  = val[DIM_W-1:0];
      REG_SRC_HEIGHT: height_reg = val[DIM_W-1:0];
      REG_X_STEP:     xstep_reg  = val;
      default:        ystep_reg  = val;
    endcase
  endtask

  task automatic set_all(int w, int h, int xs, int ys);
    drain();
    write_reg(REG_SRC_WIDTH, STEP_W'(w));
    write_reg(REG_SRC_HEIGHT, STEP_W'(h));
    write_reg(REG_X_STEP, STEP_W'(xs));
    write_reg(REG_Y_STEP, STEP_W'(ys));
  endtask

  task automatic set_steps(int xs, int ys);
    drain();
    write_reg(REG_X_STEP, STEP_W'(xs));
    write_reg(REG_Y_STEP, STEP_W'(ys));
  endtask

  function automatic int pick_step();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(1, 16383);
      2:       return $urandom_range(262145, 25'h1FFFFFF);
      3:       return 16384;
      4:       return 262144;
      default: return $urandom_range(16384, 262144);
    endcase
  endfunction

  // 4x4 checkerboard of extremes, with loads and requests past the source edge
  task automatic test_directed();
    set_all(4, 4, 65536, 65536);
    for (int y = 0; y < 4; y++)
      for (int x = 0; x < 4; x++)
        load_px(x, y, ((x + y) % 2) ? 32'hFFFFFFFF : 32'h00000000);
    load_px(4095, 4095, 32'h12345678);
    load_px(4, 0, 32'hA5A5A5A5);
    request_px(0, 0);
    request_px(3, 3);
    request_px(1, 2);
    request_px(4095, 4095);
    request_px(4095, 0);
  endtask

  task automatic test_step_extremes();
    int steps [7] = '{0, 1, 16383, 16384, 262144, 262145, 25'h1FFFFFF};
    for (int i = 0; i < 7; i++) begin
      set_steps(steps[i], steps[6 - i]);
      request_px(0, 0);
      request_px($urandom_range(0, 4095), $urandom_range(0, 4095));
      request_px(4095, 4095);
    end
  endtask

  task automatic test_size_extremes();
    set_all(256, 1, 65536, 65536);
    for (int x = 0; x < 256; x++) load_px(x, 0, $urandom());
    for (int i = 0; i < 6; i++) request_px($urandom_range(0, 4095), $urandom_range(0, 7));
    set_all(511, 0, 300000, 65536);
    for (int i = 0; i < 6; i++) request_px($urandom_range(0, 4095), $urandom_range(0, 4095));
    set_all(1, 256, 65536, 65536);
    for (int y = 0; y < 256; y++) load_px(0, y, $urandom());
    for (int i = 0; i < 6; i++) request_px($urandom_range(0, 7), $urandom_range(0, 4095));
    set_all(0, 511, 65536, 40000);
    for (int i = 0; i < 6; i++) request_px($urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  task automatic test_random();
    int w, h, ew, eh;
    while (items_sent < 1750) begin
      calm_in  = ($urandom_range(0, 4) == 0);
      calm_out = ($urandom_range(0, 4) == 0);
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      ew = (w == 0) ? 1 : w;
      eh = (h == 0) ? 1 : h;
      set_all(w, h, pick_step(), pick_step());
      for (int y = 0; y < eh; y++)
        for (int x = 0; x < ew; x++) begin
          load_px(x, y, $urandom());
          if ($urandom_range(0, 9) == 0)  // ignored, lands past the source edge
            load_px($urandom_range(ew, 4095), $urandom_range(0, 4095), $urandom());
        end
      for (int s = 0; s < 2; s++) begin
        if (s > 0) set_steps(pick_step(), pick_step());
        for (int i = 0; i < 10; i++) begin
          if ($urandom_range(0, 4) == 0)
            load_px($urandom_range(0, ew - 1), $urandom_range(0, eh - 1), $urandom());
          if ($urandom_range(0, 3) == 0)
            request_px($urandom_range(0, 4095), $urandom_range(0, 4095));
          else
            request_px($urandom_range(0, 40), $urandom_range(0, 40));
        end
      end
    end
  endtask

  initial begin
    errors = 0; accepted = 0; items_sent = 0; cycles = 0;
    calm_in = 1'b0; calm_out = 1'b0;
    width_reg = 256; height_reg = 256; xstep_reg = 65536; ystep_reg = 65536;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_SRC_WIDTH; cfg_data = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_step_extremes();
    test_size_extremes();
    test_random();
    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bbis_pkg.sv
rtl/core/bbis_mul.sv
rtl/core/bilinear_bicubic_image_scaler.sv
tb/tb_bilinear_bicubic_image_scaler.sv
